[hw/rtl/swsa_pkg.sv]
// Shared constants and types for the scroll wheel step accumulator.
package swsa_pkg;

  localparam int FRAC_BITS = 8;
  localparam int MODE_W    = 3;
  localparam int DATA_W    = 32;
  localparam int AXIS_W    = 40;
  localparam int STEP_W    = 16;
  localparam int ADDR_W    = 2;

  localparam logic [STEP_W-1:0] SCROLL_STEP_RESET = STEP_W'(15 << FRAC_BITS);
  localparam logic [STEP_W-1:0] FINE_DIV          = STEP_W'(120);

  localparam int REG_SCROLL_STEP = 0;

  localparam int PF_AXIS  = 0;
  localparam int PF_CLICK = 1;
  localparam int PF_FINE  = 2;
  localparam int PF_STOP  = 3;

  typedef enum logic [MODE_W-1:0] {
    MODE_AXIS     = 3'd0,
    MODE_DISCRETE = 3'd1,
    MODE_VALUE120 = 3'd2,
    MODE_STOP     = 3'd3,
    MODE_FRAME    = 3'd4,
    MODE_CLEAR    = 3'd5
  } mode_t;

endpackage

[hw/rtl/swsa_if.sv]
// Item channel interfaces: wheel events in, scroll steps out.
interface swsa_in_if;
  logic                                 valid;
  logic                                 ready;
  logic        [swsa_pkg::MODE_W-1:0]   mode;
  logic signed [swsa_pkg::DATA_W-1:0]   amount;

  modport source (output valid, output mode, output amount, input ready);
  modport sink   (input valid, input mode, input amount, output ready);
endinterface

interface swsa_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [swsa_pkg::DATA_W-1:0]   steps;

  modport source (output valid, output steps, input ready);
  modport sink   (input valid, input steps, output ready);
endinterface

[hw/rtl/scroll_wheel_step_accumulator_core.sv]
// Scroll wheel step accumulator: collects wheel deltas, emits whole steps on frames.
//
// Axis, discrete and value120 items are taken only while the block is idle. A frame
// item emits one steps item. A frame with value120 data pending, or with axis data
// pending and no clicks, runs a shared restoring divider (one quotient bit per
// cycle); other frames go straight to the finish state. Accepting a new item waits
// until the frame's result is loaded into the output register.
module scroll_wheel_step_accumulator_core (
  input  logic                           clk,
  input  logic                           rst,
  swsa_in_if.sink                        wheel,
  swsa_out_if.source                     result,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [swsa_pkg::ADDR_W-1:0]    paddr,
  input  logic [swsa_pkg::DATA_W-1:0]    pwdata,
  output logic [swsa_pkg::DATA_W-1:0]    prdata,
  output logic                           pready
);

  localparam int AW = swsa_pkg::AXIS_W;
  localparam int DW = swsa_pkg::DATA_W;
  localparam int SW = swsa_pkg::STEP_W;
  localparam int PW = swsa_pkg::ADDR_W;
  localparam int CW = $clog2(AW);
  localparam logic [CW-1:0] LAST_STEP = CW'(AW - 1);

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_FIN} state_t;
  typedef enum logic [1:0] {K_NONE, K_FINE, K_AXIS} kind_t;

  state_t                state;
  kind_t                 kind;
  logic                  noop;
  logic                  neg;
  logic [SW-1:0]         scroll_step;
  logic signed [AW-1:0]  axis_sum;
  logic signed [DW-1:0]  click_sum;
  logic signed [DW-1:0]  fine_sum;
  logic [3:0]            pend;
  logic [SW-1:0]         rem;
  logic [AW-1:0]         quo;
  logic [SW-1:0]         divisor;
  logic [CW-1:0]         cnt;
  logic signed [DW-1:0]  res;
  logic                  out_valid;
  logic signed [DW-1:0]  out_steps;

  logic                  accept;
  logic                  cfg_sel;
  logic                  cfg_write;
  logic [SW-1:0]         step_eff;
  logic signed [AW:0]    axis_add;
  logic signed [AW-1:0]  axis_sat;
  logic signed [DW:0]    click_add;
  logic signed [DW-1:0]  click_sat;
  logic signed [DW:0]    fine_add;
  logic signed [DW-1:0]  fine_sat;
  logic [AW-1:0]         axis_mag;
  logic [DW-1:0]         fine_mag;
  logic [SW:0]           shifted;
  logic                  ge;
  logic [SW-1:0]         rem_next;
  logic [AW-1:0]         quo_next;
  logic                  inc;
  logic [AW-1:0]         n;
  logic signed [SW+1:0]  resid;
  logic signed [AW-1:0]  axis_new;
  logic signed [DW-1:0]  fine_new;
  logic signed [DW-1:0]  frame_steps;
  logic                  load_out;

  assign wheel.ready   = (state == S_IDLE);
  assign accept        = wheel.valid && wheel.ready;
  assign result.valid  = out_valid;
  assign result.steps  = out_steps;
  assign pready        = 1'b1;
  assign cfg_sel       = (paddr == PW'(4 * swsa_pkg::REG_SCROLL_STEP));
  assign prdata        = cfg_sel ? DW'(scroll_step) : '0;
  assign cfg_write     = psel && penable && pwrite && pready && cfg_sel;
  assign load_out      = (state == S_FIN) && (!out_valid || result.ready);

  assign step_eff  = (scroll_step == '0) ? SW'(1) : scroll_step;

  // saturating accumulators
  assign axis_add  = (AW + 1)'(axis_sum) + (AW + 1)'(wheel.amount);
  assign axis_sat  = (axis_add[AW] != axis_add[AW-1]) ?
                     (axis_add[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}}) :
                     axis_add[AW-1:0];
  assign click_add = (DW + 1)'(click_sum) + (DW + 1)'(wheel.amount);
  assign click_sat = (click_add[DW] != click_add[DW-1]) ?
                     (click_add[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}}) :
                     click_add[DW-1:0];
  assign fine_add  = (DW + 1)'(fine_sum) + (DW + 1)'(wheel.amount);
  assign fine_sat  = (fine_add[DW] != fine_add[DW-1]) ?
                     (fine_add[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}}) :
                     fine_add[DW-1:0];

  assign axis_mag  = axis_sum[AW-1] ? AW'(-axis_sum) : AW'(axis_sum);
  assign fine_mag  = fine_sum[DW-1] ? DW'(-fine_sum) : DW'(fine_sum);

  // shared restoring divider step
  assign shifted   = {rem, quo[AW-1]};
  assign ge        = (shifted >= {1'b0, divisor});
  assign rem_next  = ge ? SW'(shifted - {1'b0, divisor}) : shifted[SW-1:0];
  assign quo_next  = {quo[AW-2:0], ge};

  // axis rounding: one more step when the remainder is past half a step
  assign inc       = ({rem, 1'b0} > {1'b0, divisor});
  assign n         = quo + AW'(inc);
  assign resid     = $signed({2'b00, rem}) - (inc ? $signed({2'b00, divisor}) : '0);
  assign axis_new  = AW'(neg ? -resid : resid);
  assign fine_new  = neg ? -$signed(DW'(rem)) : $signed(DW'(rem));

  always_comb begin
    case (kind)
      K_FINE: frame_steps = neg ? -$signed(quo[DW-1:0]) : $signed(quo[DW-1:0]);
      K_AXIS: begin
        if (!neg) begin
          frame_steps = (n > AW'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : $signed(n[DW-1:0]);
        end else begin
          frame_steps = (n > AW'(32'h8000_0000)) ? 32'sh8000_0000 : -$signed(n[DW-1:0]);
        end
      end
      default: frame_steps = res;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      kind        <= K_NONE;
      noop        <= 1'b0;
      scroll_step <= swsa_pkg::SCROLL_STEP_RESET;
      axis_sum    <= '0;
      click_sum   <= '0;
      fine_sum    <= '0;
      pend        <= '0;
      cnt         <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_write) begin
        scroll_step <= pwdata[SW-1:0];
      end
      if (result.valid && result.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (swsa_pkg::mode_t'(wheel.mode))
              swsa_pkg::MODE_AXIS: begin
                axis_sum                <= axis_sat;
                pend[swsa_pkg::PF_AXIS] <= 1'b1;
              end
              swsa_pkg::MODE_DISCRETE: begin
                click_sum                <= click_sat;
                pend[swsa_pkg::PF_CLICK] <= 1'b1;
              end
              swsa_pkg::MODE_VALUE120: begin
                fine_sum                <= fine_sat;
                pend[swsa_pkg::PF_FINE] <= 1'b1;
              end
              swsa_pkg::MODE_STOP: begin
                pend[swsa_pkg::PF_STOP] <= 1'b1;
              end
              swsa_pkg::MODE_FRAME: begin
                noop <= (pend == '0);
                res  <= '0;
                kind <= K_NONE;
                rem  <= '0;
                cnt  <= '0;
                if (pend[swsa_pkg::PF_FINE]) begin
                  kind    <= K_FINE;
                  quo     <= AW'(fine_mag);
                  divisor <= swsa_pkg::FINE_DIV;
                  neg     <= fine_sum[DW-1];
                  state   <= S_DIV;
                end else if (pend[swsa_pkg::PF_CLICK]) begin
                  res      <= click_sum;
                  axis_sum <= '0;
                  state    <= S_FIN;
                end else if (pend[swsa_pkg::PF_AXIS]) begin
                  kind    <= K_AXIS;
                  quo     <= axis_mag;
                  divisor <= step_eff;
                  neg     <= axis_sum[AW-1];
                  state   <= S_DIV;
                end else begin
                  state <= S_FIN;
                end
              end
              swsa_pkg::MODE_CLEAR: begin
                axis_sum  <= '0;
                click_sum <= '0;
                fine_sum  <= '0;
                pend      <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        S_DIV: begin
          rem <= rem_next;
          quo <= quo_next;
          cnt <= cnt + CW'(1);
          if (cnt == LAST_STEP) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (load_out) begin
            out_valid <= 1'b1;
            out_steps <= frame_steps;
            state     <= S_IDLE;
            if (!noop) begin
              case (kind)
                K_FINE: begin
                  fine_sum <= fine_new;
                  axis_sum <= '0;
                end
                K_AXIS:  axis_sum <= axis_new;
                default: begin
                end
              endcase
              click_sum <= '0;
              pend      <= pend & (4'b1 << swsa_pkg::PF_STOP);
              if (pend[swsa_pkg::PF_STOP]) begin
                axis_sum <= '0;
                fine_sum <= '0;
                pend     <= '0;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_out_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(state == S_FIN))
    else $error("result raised outside the finish state");

  a_rem_below_div: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (rem < divisor))
    else $error("divider remainder not below divisor");

  a_div_holds_flags: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |=> ($stable(pend) && $stable(click_sum)))
    else $error("accumulator state changed during divide");

  a_frame_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && (wheel.mode == swsa_pkg::MODE_FRAME)) |=> (state != S_IDLE))
    else $error("frame item did not start a frame sequence");

endmodule
